// ===== hdl/csvs_pkg.sv =====
// ----------------------------------------------------------------------------
// csvs_pkg
// types, codes and constants shared by the csv field splitter modules
// ----------------------------------------------------------------------------
package csvs_pkg;

    localparam int MAX_FIELD    = 4096;
    localparam int LEN_W        = 13;
    localparam int CNT_W        = 12;
    localparam int BYTE_W       = 8;
    localparam int MTDATA_W     = 24;

    localparam logic [LEN_W-1:0]  LEN_RESET   = LEN_W'(512);
    localparam logic [LEN_W-1:0]  LEN_MAX     = LEN_W'(MAX_FIELD);
    localparam logic [BYTE_W-1:0] CH_QUOTE    = 8'h22;
    localparam logic [BYTE_W-1:0] CH_COMMA    = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_WS_LO    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_WS_HI    = 8'h0D;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_EOL  = 1'b1;

    typedef enum logic [1:0] {
        CLS_OTHER,
        CLS_WS,
        CLS_COMMA,
        CLS_QUOTE
    } cls_t;

    typedef enum logic [2:0] {
        MODE_START,
        MODE_PLAIN,
        MODE_QUOTED,
        MODE_QSEEN,
        MODE_AFTER
    } mode_t;

    typedef struct packed {
        logic              cmd;
        logic [BYTE_W-1:0] data;
        cls_t              cls;
    } item_t;

    typedef struct packed {
        logic              is_end;
        logic [BYTE_W-1:0] out_byte;
        logic [CNT_W-1:0]  trim;
        logic              extra;
        logic              unterm;
        logic              last;
    } result_t;

endpackage

// ===== hdl/csv_quoted_field_splitter.sv =====
// ----------------------------------------------------------------------------
// csv_quoted_field_splitter
// splits a byte stream of csv lines into fields with quote handling
//
// channel   dir  handshake         payload
// s_*       in   tvalid/tready     tdata = line byte, tuser = end of line
// m_*       out  tvalid/tready     tdata = byte/trim/flags, tuser = field end,
//                                  tlast = last field of line
// cfg_*     in   cfg_we            cfg_wdata = max field length
//
// one input beat per cycle sustained while m_tready is high; a taken beat
// is classified and written into the queue, then popped and parsed, and any
// result goes into the output register. the parser state machine and
// counters update once per beat, which sets the rate. reset returns the
// parser to start of field and the limit to 511. a two-entry queue lets the
// input side keep taking beats while m_tready is low until the queue fills.
// ----------------------------------------------------------------------------
module csv_quoted_field_splitter
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [csvs_pkg::LEN_W-1:0]          cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [csvs_pkg::BYTE_W-1:0]         s_tdata,   // data_byte
    input  logic                                s_tuser,   // cmd
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [csvs_pkg::MTDATA_W-1:0]       m_tdata,   // out_byte, trim_count, extra_chars, unterminated, zero pad
    output logic                                m_tuser,   // is_field_end
    output logic                                m_tlast    // last_in_line
);
    import csvs_pkg::*;

    logic    push;
    item_t   push_item;
    logic    q_full;
    logic    pop;
    logic    q_valid;
    item_t   pop_item;
    result_t out_res;

    csvs_front u_front
    (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    csvs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .pop_item  (pop_item)
    );

    csvs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .pop_item  (pop_item),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {2'b00, out_res.unterm, out_res.extra, out_res.trim, out_res.out_byte};
    assign m_tuser = out_res.is_end;
    assign m_tlast = out_res.last;

endmodule

// ===== hdl/csvs_front.sv =====
// ----------------------------------------------------------------------------
// csvs_front
// takes input beats and tags each byte with its character class
// ----------------------------------------------------------------------------
module csvs_front
(
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [csvs_pkg::BYTE_W-1:0]  s_tdata,
    input  logic                         s_tuser,
    output logic                         push,
    output csvs_pkg::item_t              push_item,
    input  logic                         q_full
);
    import csvs_pkg::*;

    cls_t cls;

    always_comb
    begin
        if (s_tdata == CH_COMMA)
            cls = CLS_COMMA;
        else if (s_tdata == CH_QUOTE)
            cls = CLS_QUOTE;
        else if (s_tdata == CH_SPACE || (s_tdata >= CH_WS_LO && s_tdata <= CH_WS_HI))
            cls = CLS_WS;
        else
            cls = CLS_OTHER;
    end

    assign s_tready       = !q_full;
    assign push           = s_tvalid && !q_full;
    assign push_item.cmd  = s_tuser;
    assign push_item.data = s_tdata;
    assign push_item.cls  = cls;

endmodule

// ===== hdl/csvs_queue.sv =====
// ----------------------------------------------------------------------------
// csvs_queue
// two-entry queue of classified beats between front and back
// ----------------------------------------------------------------------------
module csvs_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  csvs_pkg::item_t  push_item,
    output logic             q_full,
    input  logic             pop,
    output logic             q_valid,
    output csvs_pkg::item_t  pop_item
);
    import csvs_pkg::*;

    item_t       mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    assign q_full   = count_reg[1];
    assign q_valid  = count_reg != 2'd0;
    assign pop_item = mem_reg[rd_ptr_reg];

endmodule

// ===== hdl/csvs_back.sv =====
// ----------------------------------------------------------------------------
// csvs_back
// field parser state machine, byte counters and output register
// ----------------------------------------------------------------------------
module csvs_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [csvs_pkg::LEN_W-1:0]  cfg_wdata,
    input  logic                        q_valid,
    input  csvs_pkg::item_t             pop_item,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output csvs_pkg::result_t           out_res
);
    import csvs_pkg::*;

    mode_t             mode_reg;
    mode_t             mode_next;
    logic [CNT_W-1:0]  lim_reg;
    logic [CNT_W-1:0]  lim_next;
    logic [CNT_W-1:0]  raw_reg;
    logic [CNT_W-1:0]  raw_next;
    logic [CNT_W-1:0]  trail_reg;
    logic [CNT_W-1:0]  trail_next;
    logic              extra_reg;
    logic              extra_next;
    logic              valid_reg;
    logic              valid_next;
    result_t           res_reg;
    result_t           res_next;
    logic              emit;
    logic              in_lim;
    logic              is_ws;
    logic [CNT_W-1:0]  room;

    // emit limit = min(len, MAX_FIELD) - 1, or 0 for a zero length
    always_comb
    begin
        lim_next = lim_reg;
        if (cfg_we)
        begin
            if (cfg_wdata == '0)
                lim_next = '0;
            else if (cfg_wdata > LEN_MAX)
                lim_next = CNT_W'(LEN_MAX - 1'b1);
            else
                lim_next = CNT_W'(cfg_wdata - 1'b1);
        end
    end

    assign pop    = q_valid && (!valid_reg || out_ready);
    assign in_lim = raw_reg < lim_reg;
    assign is_ws  = pop_item.cls == CLS_WS;
    assign room   = lim_reg - raw_reg;

    always_comb
    begin
        mode_next  = mode_reg;
        raw_next   = raw_reg;
        trail_next = trail_reg;
        extra_next = extra_reg;
        emit       = 1'b0;
        res_next   = '0;

        if (pop_item.cmd == CMD_EOL)
        begin
            emit            = 1'b1;
            res_next.is_end = 1'b1;
            res_next.last   = 1'b1;
            unique case (mode_reg)
                MODE_PLAIN:  res_next.trim = trail_reg;
                MODE_QUOTED: res_next.unterm = 1'b1;
                MODE_QSEEN, MODE_AFTER: res_next.extra = extra_reg;
                default: ;
            endcase
        end
        else
        begin
            unique case (mode_reg)
                MODE_PLAIN:
                begin
                    if (pop_item.cls == CLS_COMMA)
                    begin
                        emit          = 1'b1;
                        res_next.is_end = 1'b1;
                        res_next.trim = trail_reg;
                    end
                    else if (in_lim)
                    begin
                        raw_next          = raw_reg + 1'b1;
                        trail_next        = is_ws ? trail_reg + 1'b1 : '0;
                        emit              = 1'b1;
                        res_next.out_byte = pop_item.data;
                    end
                end
                MODE_QUOTED:
                begin
                    if (pop_item.cls == CLS_QUOTE)
                        mode_next = MODE_QSEEN;
                    else if (in_lim)
                    begin
                        raw_next          = raw_reg + 1'b1;
                        emit              = 1'b1;
                        res_next.out_byte = pop_item.data;
                    end
                end
                MODE_QSEEN, MODE_AFTER:
                begin
                    if (mode_reg == MODE_QSEEN && pop_item.cls == CLS_QUOTE)
                    begin
                        mode_next         = MODE_QUOTED;
                        raw_next          = (room >= CNT_W'(2)) ? raw_reg + CNT_W'(2) : lim_reg;
                        emit              = in_lim;
                        res_next.out_byte = CH_QUOTE;
                    end
                    else
                    begin
                        mode_next = MODE_AFTER;
                        if (pop_item.cls == CLS_COMMA)
                        begin
                            emit           = 1'b1;
                            res_next.is_end = 1'b1;
                            res_next.extra = extra_reg;
                        end
                        else if (!is_ws)
                            extra_next = 1'b1;
                    end
                end
                default:
                begin
                    case (pop_item.cls)
                        CLS_WS: ;
                        CLS_COMMA:
                        begin
                            emit            = 1'b1;
                            res_next.is_end = 1'b1;
                        end
                        CLS_QUOTE: mode_next = MODE_QUOTED;
                        default:
                        begin
                            mode_next = MODE_PLAIN;
                            if (in_lim)
                            begin
                                raw_next          = raw_reg + 1'b1;
                                trail_next        = '0;
                                emit              = 1'b1;
                                res_next.out_byte = pop_item.data;
                            end
                        end
                    endcase
                end
            endcase
        end

        // every field end returns the field state to start
        if (emit && res_next.is_end)
        begin
            mode_next  = MODE_START;
            raw_next   = '0;
            trail_next = '0;
            extra_next = 1'b0;
        end

        valid_next = (pop && emit) ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_START;
            lim_reg   <= CNT_W'(LEN_RESET - 1'b1);
            raw_reg   <= '0;
            trail_reg <= '0;
            extra_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            lim_reg   <= lim_next;
            valid_reg <= valid_next;
            if (pop)
            begin
                mode_reg  <= mode_next;
                raw_reg   <= raw_next;
                trail_reg <= trail_next;
                extra_reg <= extra_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
            res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the csv quoted field splitter
//
// a short directed line walk covers empty lines and fields, whitespace
// skipping and trimming, quote doubling, stray text after a closing quote,
// unterminated quotes, and the zero and all-ones bytes. random lines then run
// under several field length limits, from zero through the clamp at the top
// of the register range, with random gaps and stalls on both streams. every
// output beat is checked beat by beat against a behavioral parser.
// ----------------------------------------------------------------------------
module tb;

    import csvs_pkg::*;

    localparam int LIMIT = 100000;
    localparam int HOLD_CYCLES = 300;
    localparam int NUM_PHASES = 9;

    typedef struct packed {
        logic              cmd;
        logic [BYTE_W-1:0] data;
        logic              typed;
        logic [CNT_W-1:0]  trim;
        logic              extra;
        logic              unterm;
        logic              last;
    } beat_t;

    // typed rows are field end markers whose flags are plain to see
    localparam beat_t DIR_TAB [25] = '{
        '{CMD_EOL,  8'h00, 1'b1, 12'd0, 1'b0, 1'b0, 1'b1},
        '{CMD_BYTE, 8'h2C, 1'b1, 12'd0, 1'b0, 1'b0, 1'b0},
        '{CMD_BYTE, 8'h09, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0},
        '{CMD_BYTE, 8'h61, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0},
        '{CMD_BYTE, 8'h20, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0},
        '{CMD_BYTE, 8'h20, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0},
        '{CMD_BYTE, 8'h2C, 1'b1, 12'd2, 1'b0, 1'b0, 1'b0},
        '{CMD_BYTE, 8'h22, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0},
        '{CMD_BYTE, 8'h78, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0},
        '{CMD_BYTE, 8'h22, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0},
        '{CMD_BYTE, 8'h22, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0},
        '{CMD_BYTE, 8'h22, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0},
        '{CMD_BYTE, 8'h7A, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0},
        '{CMD_BYTE, 8'h2C, 1'b1, 12'd0, 1'b1, 1'b0, 1'b0},
        '{CMD_BYTE, 8'h22, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0},
        '{CMD_BYTE, 8'h71, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0},
        '{CMD_BYTE, 8'h22, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0},
        '{CMD_EOL,  8'h00, 1'b1, 12'd0, 1'b0, 1'b0, 1'b1},
        '{CMD_BYTE, 8'h22, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0},
        '{CMD_BYTE, 8'h22, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0},
        '{CMD_BYTE, 8'h22, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0},
        '{CMD_BYTE, 8'h00, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0},
        '{CMD_EOL,  8'h00, 1'b1, 12'd0, 1'b0, 1'b1, 1'b1},
        '{CMD_BYTE, 8'hFF, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0},
        '{CMD_EOL,  8'hFF, 1'b1, 12'd0, 1'b0, 1'b0, 1'b1}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [LEN_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [MTDATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    beat_t   line_q [$];
    result_t field_q [$];
    beat_t   bus_beat;

    // parser model state
    logic [LEN_W-1:0] len_reg = LEN_RESET;
    mode_t            fld_mode = MODE_START;
    int               fld_raw = 0;
    int               fld_trail = 0;
    logic             fld_extra = 1'b0;

    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    bit  hold_kick = 1'b0;
    int  n_err = 0;
    int  n_in = 0;
    int  n_out = 0;
    int  n_ends = 0;
    int  n_len = 0;
    int  cyc = 0;

    csv_quoted_field_splitter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t field_close(int trim, logic extra, logic unterm, logic last);
        result_t r;
        r = '0;
        r.is_end = 1'b1;
        r.trim = CNT_W'(trim);
        r.extra = extra;
        r.unterm = unterm;
        r.last = last;
        fld_mode = MODE_START;
        fld_raw = 0;
        fld_trail = 0;
        fld_extra = 1'b0;
        return r;
    endfunction

    function automatic result_t field_data(logic [BYTE_W-1:0] b);
        result_t r;
        r = '0;
        r.out_byte = b;
        return r;
    endfunction

    // advances the parser by one beat; returns 1 when the beat yields an output
    function automatic bit split_step(input logic cmd, input logic [BYTE_W-1:0] b,
                                      output result_t r);
        int  m;
        int  lim;
        bit  ws;
        bit  keep;
        m = (len_reg > LEN_MAX) ? MAX_FIELD : int'(len_reg);
        lim = (m == 0) ? 0 : m - 1;
        ws = (b == CH_SPACE) || (b >= CH_WS_LO && b <= CH_WS_HI);
        r = '0;
        if (cmd == CMD_EOL)
        begin
            case (fld_mode)
                MODE_PLAIN:             r = field_close(fld_trail, 1'b0, 1'b0, 1'b1);
                MODE_QUOTED:            r = field_close(0, 1'b0, 1'b1, 1'b1);
                MODE_QSEEN, MODE_AFTER: r = field_close(0, fld_extra, 1'b0, 1'b1);
                default:                r = field_close(0, 1'b0, 1'b0, 1'b1);
            endcase
            return 1'b1;
        end
        case (fld_mode)
            MODE_PLAIN:
            begin
                if (b == CH_COMMA)
                begin
                    r = field_close(fld_trail, 1'b0, 1'b0, 1'b0);
                    return 1'b1;
                end
                if (fld_raw >= lim)
                    return 1'b0;
                fld_raw++;
                fld_trail = ws ? fld_trail + 1 : 0;
                r = field_data(b);
                return 1'b1;
            end
            MODE_QUOTED:
            begin
                if (b == CH_QUOTE)
                begin
                    fld_mode = MODE_QSEEN;
                    return 1'b0;
                end
                if (fld_raw >= lim)
                    return 1'b0;
                fld_raw++;
                r = field_data(b);
                return 1'b1;
            end
            MODE_QSEEN, MODE_AFTER:
            begin
                if (fld_mode == MODE_QSEEN && b == CH_QUOTE)
                begin
                    // doubled quote inside a quoted field
                    keep = fld_raw < lim;
                    fld_raw = (lim - fld_raw >= 2) ? fld_raw + 2 : lim;
                    fld_mode = MODE_QUOTED;
                    r = field_data(CH_QUOTE);
                    return keep;
                end
                fld_mode = MODE_AFTER;
                if (b == CH_COMMA)
                begin
                    r = field_close(0, fld_extra, 1'b0, 1'b0);
                    return 1'b1;
                end
                if (!ws)
                    fld_extra = 1'b1;
                return 1'b0;
            end
            default:
            begin
                if (ws)
                    return 1'b0;
                if (b == CH_COMMA)
                begin
                    r = field_close(0, 1'b0, 1'b0, 1'b0);
                    return 1'b1;
                end
                if (b == CH_QUOTE)
                begin
                    fld_mode = MODE_QUOTED;
                    return 1'b0;
                end
                fld_mode = MODE_PLAIN;
                if (fld_raw >= lim)
                    return 1'b0;
                fld_raw++;
                fld_trail = 0;
                r = field_data(b);
                return 1'b1;
            end
        endcase
    endfunction

    function automatic void put_beat(logic cmd, logic [BYTE_W-1:0] b);
        beat_t bt;
        bt = '0;
        bt.cmd = cmd;
        bt.data = b;
        line_q.push_back(bt);
    endfunction

    function automatic logic [BYTE_W-1:0] ws_byte();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : BYTE_W'(9 + r);
    endfunction

    function automatic logic [BYTE_W-1:0] text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return BYTE_W'(8'h61 + $urandom_range(0, 25));
        if (r < 70)
            return ws_byte();
        if (r < 85)
            return BYTE_W'($urandom_range(0, 255));
        return CH_QUOTE;
    endfunction

    function automatic void gen_field(bit last_fld);
        int kind;
        logic [BYTE_W-1:0] b;
        kind = $urandom_range(0, 9);
        repeat ($urandom_range(0, 2))
            put_beat(CMD_BYTE, ws_byte());
        if (kind >= 2 && kind < 6)
        begin
            repeat ($urandom_range(1, 7))
            begin
                b = text_byte();
                put_beat(CMD_BYTE, (b == CH_COMMA) ? 8'h5F : b);
            end
            repeat ($urandom_range(0, 3))
                put_beat(CMD_BYTE, ws_byte());
        end
        else if (kind >= 6)
        begin
            put_beat(CMD_BYTE, CH_QUOTE);
            repeat ($urandom_range(0, 6))
            begin
                b = text_byte();
                put_beat(CMD_BYTE, b);
                if (b == CH_QUOTE)
                    put_beat(CMD_BYTE, CH_QUOTE);
            end
            if (!(last_fld && kind == 9))
            begin
                put_beat(CMD_BYTE, CH_QUOTE);
                repeat ($urandom_range(0, 2))
                    put_beat(CMD_BYTE, ws_byte());
                if ($urandom_range(0, 3) == 0)
                begin
                    b = text_byte();
                    put_beat(CMD_BYTE, (b == CH_COMMA) ? 8'h21 : b);
                end
            end
        end
    endfunction

    function automatic int gen_line();
        int nf;
        int size0;
        size0 = line_q.size();
        if ($urandom_range(0, 99) < 12)
        begin
            // noise line
            repeat ($urandom_range(0, 10))
                put_beat(CMD_BYTE, BYTE_W'($urandom_range(0, 255)));
        end
        else
        begin
            nf = $urandom_range(1, 4);
            for (int f = 0; f < nf; f++)
            begin
                if (f > 0)
                    put_beat(CMD_BYTE, CH_COMMA);
                gen_field(f == nf - 1);
            end
        end
        put_beat(CMD_EOL, BYTE_W'($urandom_range(0, 255)));
        return line_q.size() - size0;
    endfunction

    task automatic gen_lines(int n);
        int cnt;
        cnt = 0;
        while (cnt < n)
            cnt += gen_line();
    endtask

    task automatic wait_drain();
        do
            @(negedge clk);
        while (line_q.size() != 0 || s_tvalid || field_q.size() != 0);
    endtask

    task automatic write_len(int v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= LEN_W'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
        len_reg = LEN_W'(v);
        n_len++;
    endtask

    function automatic void chk(string nm, int e, int a);
        if (e != a)
        begin
            n_err++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, e, a);
        end
    endfunction

    // sender
    always @(posedge clk)
    begin : drv
        logic    nxt_valid;
        result_t r;
        bit      has;
        nxt_valid = s_tvalid;
        if (s_tvalid && s_tready)
        begin
            n_in++;
            has = split_step(bus_beat.cmd, bus_beat.data, r);
            if (bus_beat.typed)
            begin
                r = '0;
                r.is_end = 1'b1;
                r.trim = bus_beat.trim;
                r.extra = bus_beat.extra;
                r.unterm = bus_beat.unterm;
                r.last = bus_beat.last;
                has = 1'b1;
            end
            if (has)
                field_q.push_back(r);
            nxt_valid = 1'b0;
        end
        if (!nxt_valid && line_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
        begin
            bus_beat = line_q.pop_front();
            s_tdata <= bus_beat.data;
            s_tuser <= bus_beat.cmd;
            nxt_valid = 1'b1;
        end
        s_tvalid <= nxt_valid;
    end

    // receiver, with its own hold-off counter
    always @(posedge clk)
    begin : rcv
        static bit kick_seen = 1'b0;
        static int hold_left = 0;
        if (hold_kick != kick_seen)
        begin
            kick_seen = hold_kick;
            hold_left = HOLD_CYCLES;
        end
        else if (hold_left > 0)
            hold_left--;
        m_tready <= rst_n && hold_left == 0 && $urandom_range(0, 99) >= rx_stall_pct;
    end

    // output check
    always @(posedge clk)
    begin : mon
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_out++;
            if (field_q.size() == 0)
            begin
                n_err++;
                $display("%0t: unexpected beat, expected none, actual tdata %h tuser %b",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                want = field_q.pop_front();
                if (m_tuser)
                    n_ends++;
                chk("is_field_end", want.is_end, m_tuser);
                chk("out_byte", want.out_byte, m_tdata[7:0]);
                chk("trim_count", want.trim, m_tdata[19:8]);
                chk("extra_chars", want.extra, m_tdata[20]);
                chk("unterminated", want.unterm, m_tdata[21]);
                chk("pad", 0, m_tdata[23:22]);
                chk("last_in_line", want.last, m_tlast);
            end
        end
    end

    always @(posedge clk)
    begin
        cyc++;
        if (cyc > LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cyc, field_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : main_seq
        static int plens [NUM_PHASES] = '{3, 1, 0, 2, 8191, 4096, 17, 5, 512};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (DIR_TAB[i])
            line_q.push_back(DIR_TAB[i]);
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drain();
            // let the last beats that make no output clear the pipeline
            repeat (8) @(posedge clk);
            write_len(plens[p]);
            tx_idle_pct = (p % 4 == 1) ? 51 : (p % 4 == 3) ? 25 : 0;
            rx_stall_pct = (p % 4 == 2) ? 51 : (p % 4 == 3) ? 25 : 0;
            if (p == 4)
                hold_kick <= ~hold_kick;
            if (p == 6)
            begin
                gen_lines(24);
                wait_drain();
                gen_lines(24);
            end
            else
                gen_lines(48);
        end
        wait_drain();
        repeat (10) @(posedge clk);
        $display("ran %0d beats in and %0d beats out, %0d of them field ends",
                 n_in, n_out, n_ends);
        $display("length limit written %0d times, from 0 up to 8191, with stalls on both sides",
                 n_len);
        if (n_err == 0 && field_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== csv_quoted_field_splitter.f =====
hdl/csvs_pkg.sv
hdl/csvs_front.sv
hdl/csvs_queue.sv
hdl/csvs_back.sv
hdl/csv_quoted_field_splitter.sv
tb/tb.sv
